[rtl/core/abs_pkg.sv]
// Shared types and constants for the alternating-bit sender.
`default_nettype none

package abs_pkg;

   localparam int QUEUE_SLOTS_DEF = 16;
   localparam int TAG_BITS_DEF    = 16;

   localparam int TIMEOUT_BITS = 16;
   localparam int REQ_TYPE_BITS = 2;
   localparam int STATUS_BITS = 4;
   localparam int QCOUNT_BITS = 4;

   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd30;

   typedef enum logic [REQ_TYPE_BITS-1:0] {
      REQ_MSG  = 2'd0,
      REQ_ACK  = 2'd1,
      REQ_TICK = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_SENT       = 4'd0,
      ST_QUEUED     = 4'd1,
      ST_FULL       = 4'd2,
      ST_UNEXPECTED = 4'd3,
      ST_CORRUPT    = 4'd4,
      ST_WRONG      = 4'd5,
      ST_IDLE       = 4'd6,
      ST_NEXT       = 4'd7,
      ST_RESENT     = 4'd8,
      ST_TICK       = 4'd9
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_flags_type;

endpackage

`default_nettype wire

[rtl/core/alternating_bit_sender.sv]
// Top level of the alternating-bit sender: input register, decision logic, result register.
// Requests wait in the input register; results are held in the result register for rsp_.
// Throughput: one transaction per cycle, sustained, while rsp_tready stays high;
// the single input register and single result register set that figure.
// Reset (synchronous, active high) returns to idle with sequence bit 0, an empty
// queue and a timeout of 30 ticks; queue storage itself is not cleared.
`default_nettype none

module alternating_bit_sender
   import abs_pkg::*;
#(
   parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
   parameter int TAG_BITS    = TAG_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Configuration: timeout in ticks.
   input  wire logic                                   csr_write_en,
   input  wire logic [TIMEOUT_BITS-1:0]                csr_write_data,
   // Request channel.
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // tdata from bit 0: msg_tag, ack_number, checksum_ok, zero fill.
   input  wire logic [((TAG_BITS+2+7)/8)*8-1:0]        req_tdata,
   // tuser: req_type.
   input  wire logic [REQ_TYPE_BITS-1:0]               req_tuser,
   // Response channel.
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // tdata from bit 0: send_valid, send_seq, send_tag, queued_count, zero fill.
   output logic [((TAG_BITS+2+QCOUNT_BITS+7)/8)*8-1:0] rsp_tdata,
   // tuser: status.
   output logic [STATUS_BITS-1:0]                      rsp_tuser
);

   localparam int RSP_W = ((TAG_BITS + 2 + QCOUNT_BITS + 7) / 8) * 8;

   // Input register: holds one request transaction until the decision
   // logic can hand its result to the result register.
   logic                     in_valid_ff;
   logic [REQ_TYPE_BITS-1:0] in_type_ff;
   logic [TAG_BITS-1:0]      in_tag_ff;
   logic                     in_ack_ff;
   logic                     in_csok_ff;

   // Result register.
   logic                     out_valid_ff;
   logic                     out_send_valid_ff;
   logic                     out_send_seq_ff;
   logic [TAG_BITS-1:0]      out_send_tag_ff;
   status_type               out_status_ff;
   logic [QCOUNT_BITS-1:0]   out_count_ff;

   logic                     advance;
   logic                     req_accept;

   queue_cmd_type            qcmd;
   queue_flags_type          qflags;
   logic [TAG_BITS-1:0]      head_tag;
   logic [QCOUNT_BITS-1:0]   count_next;

   logic                     send_valid;
   logic                     send_seq;
   logic [TAG_BITS-1:0]      send_tag;
   status_type               status;

   // The held transaction is processed in the cycle the result register
   // is free or is being emptied; protocol state updates in that cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff <= req_tuser;
         in_tag_ff  <= req_tdata[TAG_BITS-1:0];
         in_ack_ff  <= req_tdata[TAG_BITS];
         in_csok_ff <= req_tdata[TAG_BITS+1];
      end
   end

   abs_ctrl #(
      .TAG_BITS(TAG_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .ev_valid       (advance),
      .ev_type        (in_type_ff),
      .ev_tag         (in_tag_ff),
      .ev_ack_number  (in_ack_ff),
      .ev_checksum_ok (in_csok_ff),
      .qflags         (qflags),
      .head_tag       (head_tag),
      .qcmd           (qcmd),
      .send_valid     (send_valid),
      .send_seq       (send_seq),
      .send_tag       (send_tag),
      .status         (status)
   );

   abs_queue #(
      .QUEUE_SLOTS(QUEUE_SLOTS),
      .TAG_BITS   (TAG_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .cmd        (qcmd),
      .push_tag   (in_tag_ff),
      .flags      (qflags),
      .head_tag   (head_tag),
      .count_next (count_next)
   );

   // The result register takes a new transaction whenever the input
   // register advances, so a result taken in one cycle is replaced by the
   // next one at the same edge with no bubble.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_send_valid_ff <= send_valid;
         out_send_seq_ff   <= send_seq;
         out_send_tag_ff   <= send_tag;
         out_status_ff     <= status;
         out_count_ff      <= count_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({out_count_ff, out_send_tag_ff, out_send_seq_ff,
                               out_send_valid_ff});
   assign rsp_tuser  = out_status_ff;

endmodule

`default_nettype wire

[rtl/core/abs_queue.sv]
// Ring queue of pending message tags with a registered head read.
`default_nettype none

module abs_queue
   import abs_pkg::*;
#(
   parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
   parameter int TAG_BITS    = TAG_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire queue_cmd_type          cmd,
   input  wire logic [TAG_BITS-1:0]    push_tag,
   output queue_flags_type             flags,
   output logic [TAG_BITS-1:0]         head_tag,
   output logic [QCOUNT_BITS-1:0]      count_next
);

   localparam int IDX_W = $clog2(QUEUE_SLOTS);
   localparam int CNT_W = (IDX_W + 1 > QCOUNT_BITS) ? IDX_W + 1 : QCOUNT_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SLOTS - 1);
   localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(QUEUE_SLOTS);

   logic [TAG_BITS-1:0] mem [QUEUE_SLOTS];

   logic [IDX_W-1:0]    rd_ff, rd_in;
   logic [IDX_W-1:0]    wr_ff, wr_in;
   logic [TAG_BITS-1:0] head_ff;
   logic [CNT_W-1:0]    cnt;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      next_slot = (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   always_comb begin
      flags.empty = (rd_ff == wr_ff);
      flags.full  = (next_slot(wr_ff) == rd_ff);
      rd_in = cmd.pop  ? next_slot(rd_ff) : rd_ff;
      wr_in = cmd.push ? next_slot(wr_ff) : wr_ff;
      if (wr_in >= rd_in) begin
         cnt = CNT_W'(wr_in) - CNT_W'(rd_in);
      end else begin
         cnt = CNT_W'(wr_in) + SLOTS_C - CNT_W'(rd_in);
      end
      count_next = cnt[QCOUNT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
   end

   // Storage and head read; a write to the slot about to become the head
   // is forwarded so head_ff always mirrors the entry at the read pointer.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_ff] <= push_tag;
      end
      if (cmd.push && (wr_ff == rd_in)) begin
         head_ff <= push_tag;
      end else begin
         head_ff <= mem[rd_in];
      end
   end

   assign head_tag = head_ff;

endmodule

`default_nettype wire

[rtl/core/abs_ctrl.sv]
// Protocol state and per-event decision logic of the sender.
`default_nettype none

module abs_ctrl
   import abs_pkg::*;
#(
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_en,
   input  wire logic [TIMEOUT_BITS-1:0] csr_write_data,
   input  wire logic                    ev_valid,
   input  wire logic [REQ_TYPE_BITS-1:0] ev_type,
   input  wire logic [TAG_BITS-1:0]     ev_tag,
   input  wire logic                    ev_ack_number,
   input  wire logic                    ev_checksum_ok,
   input  wire queue_flags_type         qflags,
   input  wire logic [TAG_BITS-1:0]     head_tag,
   output queue_cmd_type                qcmd,
   output logic                         send_valid,
   output logic                         send_seq,
   output logic [TAG_BITS-1:0]          send_tag,
   output status_type                   status
);

   logic [TIMEOUT_BITS-1:0] timeout_ff;
   logic                    waiting_ff, waiting_in;
   logic                    seq_ff, seq_in;
   logic [TAG_BITS-1:0]     last_tag_ff, last_tag_in;
   logic [TIMEOUT_BITS-1:0] countdown_ff, countdown_in;

   always_comb begin
      waiting_in   = waiting_ff;
      seq_in       = seq_ff;
      last_tag_in  = last_tag_ff;
      countdown_in = countdown_ff;
      qcmd         = '0;
      send_valid   = 1'b0;
      send_seq     = 1'b0;
      send_tag     = '0;
      status       = ST_TICK;
      if (ev_valid) begin
         case (req_kind_type'(ev_type))
            REQ_MSG: begin
               if (!waiting_ff) begin
                  send_valid = 1'b1;
                  send_tag   = ev_tag;
                  status     = ST_SENT;
               end else if (qflags.full) begin
                  // Oldest entry is discarded and the new message dropped.
                  qcmd.pop = 1'b1;
                  status   = ST_FULL;
               end else begin
                  qcmd.push = 1'b1;
                  status    = ST_QUEUED;
               end
            end
            REQ_ACK: begin
               if (!waiting_ff) begin
                  status = ST_UNEXPECTED;
               end else if (!ev_checksum_ok) begin
                  status = ST_CORRUPT;
               end else if (ev_ack_number != seq_ff) begin
                  status = ST_WRONG;
               end else begin
                  seq_in = ~seq_ff;
                  if (!qflags.empty) begin
                     qcmd.pop   = 1'b1;
                     send_valid = 1'b1;
                     send_tag   = head_tag;
                     status     = ST_NEXT;
                  end else begin
                     waiting_in   = 1'b0;
                     countdown_in = '0;
                     status       = ST_IDLE;
                  end
               end
            end
            REQ_TICK: begin
               if (waiting_ff) begin
                  if (countdown_ff <= TIMEOUT_BITS'(1)) begin
                     send_valid = 1'b1;
                     send_tag   = last_tag_ff;
                     status     = ST_RESENT;
                  end else begin
                     countdown_in = countdown_ff - 1'b1;
                  end
               end
            end
            default: begin
               status = ST_TICK;
            end
         endcase
         if (send_valid) begin
            last_tag_in  = send_tag;
            waiting_in   = 1'b1;
            countdown_in = timeout_ff;
            send_seq     = seq_in;
         end
      end
   end

   // The timeout register starts at the reset value and takes every write made outside reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         waiting_ff   <= 1'b0;
         seq_ff       <= 1'b0;
         last_tag_ff  <= '0;
         countdown_ff <= '0;
      end else begin
         if (csr_write_en) begin
            timeout_ff <= csr_write_data;
         end
         waiting_ff   <= waiting_in;
         seq_ff       <= seq_in;
         last_tag_ff  <= last_tag_in;
         countdown_ff <= countdown_in;
      end
   end

endmodule

`default_nettype wire

[tb/alternating_bit_sender_test.sv]
// Self-checking stream testbench for the alternating-bit sender top level.
`default_nettype none

module alternating_bit_sender_test;
   import abs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAG_W     = TAG_BITS_DEF;
   localparam int RING_W    = 4;                         // log2 of QUEUE_SLOTS_DEF
   localparam int REQ_W     = ((TAG_W + 2 + 7) / 8) * 8;
   localparam int RSP_W     = ((TAG_W + 2 + QCOUNT_BITS + 7) / 8) * 8;
   localparam int PHASE_LEN = 230;
   localparam int CYCLE_CAP = 400000;

   // The package has no member for the fourth request code; the block must treat it as a no-op.
   localparam logic [REQ_TYPE_BITS-1:0] REQ_RESERVED = 2'd3;

   typedef enum int {PAT_MIX, PAT_FLOOD, PAT_TICKS} pattern_type;

   // One response transaction, unpacked into its fields.
   typedef struct packed {
      logic                   send_valid;
      logic                   send_seq;
      logic [TAG_W-1:0]       send_tag;
      logic [STATUS_BITS-1:0] status;
      logic [QCOUNT_BITS-1:0] queued_count;
   } outcome_type;

   // One line of the directed script: either a timeout write or a request transaction.
   typedef struct {
      bit                       is_csr;
      logic [TIMEOUT_BITS-1:0]  csr_value;
      logic [REQ_TYPE_BITS-1:0] kind;
      logic [TAG_W-1:0]         tag;
      logic                     ackn;
      logic                     csok;
      bit                       typed;
      outcome_type              want;
   } script_row_type;

   logic                    clock;
   logic                    reset          = 1'b1;
   logic                    csr_write_en   = 1'b0;
   logic [TIMEOUT_BITS-1:0] csr_write_data = '0;
   logic                    req_tvalid     = 1'b0;
   logic                    req_tready;
   logic [REQ_W-1:0]        req_tdata      = '0;
   logic [REQ_TYPE_BITS-1:0] req_tuser     = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready     = 1'b0;
   logic [RSP_W-1:0]        rsp_tdata;
   logic [STATUS_BITS-1:0]  rsp_tuser;

   alternating_bit_sender DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser)
   );

   // Expected responses, oldest first, and the error tally.
   outcome_type    expected_outcomes[$];
   int             mismatch_count = 0;
   int             cycle_count    = 0;
   script_row_type script[$];

   // Idle probability in percent shared by both sides; calm turns idling off on both for the tail.
   int          idle_odds = 0;
   bit          calm      = 1'b0;
   int          stall_left = 0;

   // Predictor state: the sender as the network sees it.
   logic                    snd_waiting;
   logic                    snd_seq;
   logic [TAG_W-1:0]        snd_last_tag;
   logic [TIMEOUT_BITS-1:0] snd_countdown;
   logic [TAG_W-1:0]        snd_ring [0:(1<<RING_W)-1];
   logic [RING_W-1:0]       snd_rd;
   logic [RING_W-1:0]       snd_wr;
   logic [TIMEOUT_BITS-1:0] snd_timeout;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("alternating_bit_sender_test: done, errors");
         $finish;
      end
   end

   // Response side: ready is dropped at random while idling is enabled.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
         stall_left <= $urandom_range(1, 6) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string label, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
   endtask

   // Every accepted response transaction is compared with the oldest expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with nothing expected, expected none, actual %h/%0h",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = expected_outcomes.pop_front();
            check_field("send_valid", want.send_valid, rsp_tdata[0]);
            check_field("send_seq", want.send_seq, rsp_tdata[1]);
            check_field("send_tag", want.send_tag, rsp_tdata[TAG_W+1:2]);
            check_field("status", want.status, rsp_tuser);
            check_field("queued_count", want.queued_count,
                        rsp_tdata[TAG_W+QCOUNT_BITS+1:TAG_W+2]);
         end
      end
   end

   task automatic predictor_reset();
      snd_waiting   = 1'b0;
      snd_seq       = 1'b0;
      snd_last_tag  = '0;
      snd_countdown = '0;
      snd_rd        = '0;
      snd_wr        = '0;
      snd_timeout   = TIMEOUT_RESET;
   endtask

   // Hands a packet to the network: remembers it for retransmission and rearms the timer.
   task automatic launch_packet(input logic [TAG_W-1:0] tag, inout outcome_type o);
      snd_last_tag  = tag;
      snd_waiting   = 1'b1;
      snd_countdown = snd_timeout;
      o.send_valid  = 1'b1;
      o.send_seq    = snd_seq;
      o.send_tag    = tag;
   endtask

   // Advances the predictor by one event and returns the response it must produce.
   task automatic predict_outcome(input logic [REQ_TYPE_BITS-1:0] kind,
                                  input logic [TAG_W-1:0] tag, input logic ackn,
                                  input logic csok, output outcome_type o);
      o        = '0;
      o.status = ST_TICK;
      case (kind)
         REQ_MSG: begin
            if (!snd_waiting) begin
               launch_packet(tag, o);
               o.status = ST_SENT;
            end else if (RING_W'(snd_wr + 1) == snd_rd) begin
               // A full ring loses its oldest entry and the new message as well.
               snd_rd   = RING_W'(snd_rd + 1);
               o.status = ST_FULL;
            end else begin
               snd_ring[snd_wr] = tag;
               snd_wr   = RING_W'(snd_wr + 1);
               o.status = ST_QUEUED;
            end
         end
         REQ_ACK: begin
            if (!snd_waiting) begin
               o.status = ST_UNEXPECTED;
            end else if (!csok) begin
               o.status = ST_CORRUPT;
            end else if (ackn != snd_seq) begin
               o.status = ST_WRONG;
            end else begin
               snd_seq = ~snd_seq;
               if (snd_rd != snd_wr) begin
                  launch_packet(snd_ring[snd_rd], o);
                  snd_rd   = RING_W'(snd_rd + 1);
                  o.status = ST_NEXT;
               end else begin
                  snd_waiting   = 1'b0;
                  snd_countdown = '0;
                  o.status      = ST_IDLE;
               end
            end
         end
         REQ_TICK: begin
            // A countdown of zero or one fires on this tick, so a zero timeout acts as one.
            if (snd_waiting) begin
               if (snd_countdown <= TIMEOUT_BITS'(1)) begin
                  launch_packet(snd_last_tag, o);
                  o.status = ST_RESENT;
               end else begin
                  snd_countdown = snd_countdown - 1'b1;
               end
            end
         end
         default: ;
      endcase
      o.queued_count = QCOUNT_BITS'(snd_wr - snd_rd);
   endtask

   // Offers one request transaction, waits for acceptance and records what must come back.
   task automatic drive_request(input logic [REQ_TYPE_BITS-1:0] kind,
                                input logic [TAG_W-1:0] tag, input logic ackn,
                                input logic csok, input bit typed, input outcome_type want);
      outcome_type pred;
      if (!calm && idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({csok, ackn, tag});
      req_tuser  <= kind;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_outcome(kind, tag, ackn, csok, pred);
      expected_outcomes.push_back(typed ? want : pred);
   endtask

   // Holds off the request side until every expected response has been seen.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_BITS-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      snd_timeout     = value;
   endtask

   task automatic add_step(input logic [REQ_TYPE_BITS-1:0] kind, input logic [TAG_W-1:0] tag,
                           input logic ackn, input logic csok);
      script_row_type row;
      row = '{default: '0};
      row.kind = kind;
      row.tag  = tag;
      row.ackn = ackn;
      row.csok = csok;
      script.push_back(row);
   endtask

   // A row whose response is known by inspection: send_valid, seq, tag, status, count.
   task automatic add_known(input logic [REQ_TYPE_BITS-1:0] kind, input logic [TAG_W-1:0] tag,
                            input logic ackn, input logic csok, input logic sv,
                            input logic sq, input logic [TAG_W-1:0] stag,
                            input logic [STATUS_BITS-1:0] st, input logic [QCOUNT_BITS-1:0] qc);
      add_step(kind, tag, ackn, csok);
      script[$].typed = 1'b1;
      script[$].want  = '{send_valid: sv, send_seq: sq, send_tag: stag, status: st,
                          queued_count: qc};
   endtask

   task automatic add_csr(input logic [TIMEOUT_BITS-1:0] value);
      script_row_type row;
      row = '{default: '0};
      row.is_csr    = 1'b1;
      row.csr_value = value;
      script.push_back(row);
   endtask

   // Random event drawn with knowledge of the predictor, so most acknowledgements match.
   task automatic choose_event(input pattern_type pat, output logic [REQ_TYPE_BITS-1:0] kind,
                               output logic [TAG_W-1:0] tag, output logic ackn,
                               output logic csok);
      int roll;
      roll = $urandom_range(0, 99);
      tag  = TAG_W'($urandom());
      ackn = 1'($urandom());
      csok = 1'($urandom());
      case (pat)
         PAT_FLOOD: kind = REQ_MSG;
         PAT_TICKS: kind = REQ_TICK;
         default: begin
            if (roll < 35)      kind = REQ_MSG;
            else if (roll < 65) kind = REQ_ACK;
            else if (roll < 95) kind = REQ_TICK;
            else                kind = REQ_RESERVED;
         end
      endcase
      if (kind == REQ_ACK && $urandom_range(0, 3) != 0) begin
         ackn = snd_seq;
         csok = 1'b1;
      end
   endtask

   initial begin
      logic [TIMEOUT_BITS-1:0]  phase_timeout [0:7];
      logic [REQ_TYPE_BITS-1:0] kind;
      logic [TAG_W-1:0]         tag;
      logic                     ackn;
      logic                     csok;
      pattern_type              pat;
      int                       burst;
      int                       sent;
      outcome_type              none;

      none = '0;
      predictor_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed script. From reset: stray acknowledgements, ticks and the reserved code
      // while idle, then one full exchange with corrupt, wrong and matching acknowledgements.
      add_known(REQ_ACK,      16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, ST_UNEXPECTED, 4'd0);
      add_known(REQ_TICK,     16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, ST_TICK,       4'd0);
      add_known(REQ_RESERVED, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, ST_TICK,       4'd0);
      add_known(REQ_MSG,      16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 16'hFFFF, ST_SENT,       4'd0);
      add_known(REQ_MSG,      16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, ST_QUEUED,     4'd1);
      add_known(REQ_ACK,      16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, ST_CORRUPT,    4'd1);
      add_known(REQ_ACK,      16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, ST_WRONG,      4'd1);
      add_known(REQ_RESERVED, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, ST_TICK,       4'd1);
      add_known(REQ_ACK,      16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 16'h0000, ST_NEXT,       4'd0);
      add_known(REQ_ACK,      16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, ST_IDLE,       4'd0);
      add_known(REQ_MSG,      16'hA5A5, 1'b0, 1'b0, 1'b1, 1'b0, 16'hA5A5, ST_SENT,       4'd0);
      // Two queued behind one in flight, drained by alternating acknowledgements.
      add_step(REQ_MSG, 16'h5A5A, 1'b0, 1'b0);
      add_step(REQ_MSG, 16'h8001, 1'b1, 1'b0);
      add_step(REQ_ACK, 16'h0000, 1'b1, 1'b1);
      add_step(REQ_ACK, 16'h0000, 1'b0, 1'b1);
      add_step(REQ_ACK, 16'h0000, 1'b1, 1'b1);
      add_step(REQ_ACK, 16'h0000, 1'b0, 1'b1);
      // A zero timeout retransmits on every tick; then a timeout of one tick.
      add_csr(16'd0);
      add_step(REQ_MSG,  16'h1234, 1'b0, 1'b0);
      add_step(REQ_TICK, 16'h0000, 1'b0, 1'b0);
      add_step(REQ_TICK, 16'hFFFF, 1'b1, 1'b1);
      add_csr(16'd1);
      add_step(REQ_TICK, 16'h0000, 1'b0, 1'b0);
      add_step(REQ_ACK,  16'h0000, 1'b1, 1'b1);

      idle_odds = 20;
      foreach (script[i]) begin
         if (script[i].is_csr) begin
            drain_responses();
            write_timeout(script[i].csr_value);
         end else begin
            drive_request(script[i].kind, script[i].tag, script[i].ackn, script[i].csok,
                          script[i].typed, script[i].want);
         end
      end

      // Random phases, each under its own timeout, the extremes among them. The last
      // phase runs with no idling on either side.
      phase_timeout[0] = 16'hFFFF;
      phase_timeout[1] = 16'd2;
      phase_timeout[2] = 16'd0;
      phase_timeout[3] = 16'd7;
      phase_timeout[4] = TIMEOUT_RESET;
      phase_timeout[5] = 16'd1;
      phase_timeout[6] = TIMEOUT_BITS'($urandom_range(3, 40));
      phase_timeout[7] = TIMEOUT_BITS'($urandom_range(1, 12));
      for (int ph = 0; ph < 8; ph++) begin
         drain_responses();
         write_timeout(phase_timeout[ph]);
         calm = (ph == 7);
         sent = 0;
         while (sent < PHASE_LEN) begin
            if ($urandom_range(0, 7) == 0)      pat = PAT_FLOOD;
            else if ($urandom_range(0, 6) == 0) pat = PAT_TICKS;
            else                                pat = PAT_MIX;
            case (pat)
               PAT_FLOOD: burst = 18;
               PAT_TICKS: burst = (snd_timeout < 40) ? snd_timeout + 1 : 40;
               default:   burst = $urandom_range(1, 12);
            endcase
            idle_odds = ($urandom_range(0, 2) == 0) ? 0 : 20;
            repeat (burst) begin
               choose_event(pat, kind, tag, ackn, csok);
               drive_request(kind, tag, ackn, csok, 1'b0, none);
               sent++;
            end
         end
      end

      drain_responses();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("alternating_bit_sender_test: done, clean");
      end else begin
         $display("alternating_bit_sender_test: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

[alternating_bit_sender.f]
rtl/core/abs_pkg.sv
rtl/core/abs_queue.sv
rtl/core/abs_ctrl.sv
rtl/core/alternating_bit_sender.sv
tb/alternating_bit_sender_test.sv
